### src/class_priority_queue_top_assert.svh
// Assertion macros used by the priority queue top level
`ifndef CLASS_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define CLASS_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define CPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define CPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### src/cpq_pkg.sv
// Shared types and constants for the class priority queue
`timescale 1ns / 1ps
`default_nettype none

package cpq_pkg;

	// default buffer depth
	localparam int DEPTH_DEF = 16;

	// request opcodes
	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_DEQUEUE = 1'b1
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_DEQUEUED = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMPACT,
		S_FINISH
	} state_t;

	// one buffered request
	typedef struct packed {
		logic [1:0]  cls;
		logic [2:0]  svc;
		logic [15:0] arr;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

### src/cpq_ram.sv
// Generic single write, single read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module cpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### src/class_priority_queue_top.sv
// Top level of the three-class strict priority request queue
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  in      | in_valid in_stall opcode req_class service_len now | in
//  out     | out_valid out_stall status out_class out_service   | out
//          | wait_time occupancy drop_count                   |
//
// Insert, drop and empty dequeue go from IDLE straight to FINISH, then to the output register.
// Dequeue: IDLE, then SCAN over the N entries held, then COMPACT over the entries
//   behind the position taken (skipped if it is the last), then FINISH. Paced by
//   the one RAM read port: one scan read, then one compaction read/write per cycle.
// Reset clears occupancy, drop counters and handshakes; the RAM is not cleared.
// A result waits in the output register; the next item is taken meanwhile and
//   holds in its final state until the output register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "class_priority_queue_top_assert.svh"

module class_priority_queue_top
	import cpq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [1:0]  req_class,
	input  wire logic [2:0]  service_len,
	input  wire logic [15:0] now,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [1:0]       out_class,
	output logic [2:0]       out_service,
	output logic [15:0]      wait_time,
	output logic [4:0]       occupancy,
	output logic [15:0]      drop_count
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q;
	logic [IW-1:0]   idx_q;
	logic [15:0]     now_q;
	logic [1:0]      best_cls_q;
	logic [IW-1:0]   best_pos_q;
	logic [2:0]      best_svc_q;
	logic [15:0]     best_arr_q;
	status_t         res_status_q;
	logic [15:0]     res_drop_q;
	logic [15:0]     drop_q [3];

	logic            out_valid_q;
	status_t         out_status_q;
	logic [1:0]      out_class_q;
	logic [2:0]      out_service_q;
	logic [15:0]     out_wait_q;
	logic [4:0]      out_occ_q;
	logic [15:0]     out_drop_q;

	logic            accept;
	logic            full;
	logic            last;
	logic            take;
	logic            pos_last;
	logic            out_free;
	logic            deq_res;
	logic [IW-1:0]   pos_nx;
	logic [1:0]      dsel;
	logic [15:0]     drop_cur;
	logic [15:0]     drop_inc;
	logic [31:0]     cnt_ext;
	entry_t          rd_ent;
	entry_t          wr_ent;

	logic            ram_wr_en;
	logic [IW-1:0]   ram_wr_addr;
	logic [IW-1:0]   ram_rd_addr;
	logic [ENTRY_W-1:0] ram_rd_data;

	// entry storage
	cpq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (wr_ent),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// shared compare and bookkeeping terms
	always_comb begin
		accept   = in_valid && !in_stall;
		full     = (count_q == CW'(DEPTH));
		rd_ent   = entry_t'(ram_rd_data);
		last     = (CW'(idx_q) == count_q - CW'(1));
		take     = (idx_q == '0) || (rd_ent.cls < best_cls_q);
		pos_nx   = take ? idx_q : best_pos_q;
		pos_last = (CW'(pos_nx) == count_q - CW'(1));
		out_free = !out_valid_q || !out_stall;
		dsel     = req_class - 2'd1;
		drop_cur = drop_q[dsel];
		drop_inc = (drop_cur == 16'hFFFF) ? drop_cur : drop_cur + 16'd1;
		cnt_ext  = 32'(count_q);
		deq_res  = (res_status_q == ST_DEQUEUED);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_DEQUEUE && count_q != '0) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SCAN: begin
				if (last) begin
					state_d = pos_last ? S_FINISH : S_COMPACT;
				end
			end
			S_COMPACT: begin
				if (last) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		in_stall    = (state_q != S_IDLE);
		ram_wr_en   = 1'b0;
		ram_wr_addr = idx_q - IW'(1);
		ram_rd_addr = '0;
		wr_ent      = rd_ent;
		case (state_q)
			S_IDLE: begin
				ram_wr_en   = accept && (opcode == OP_INSERT) && (req_class != 2'd0) && !full;
				ram_wr_addr = count_q[IW-1:0];
				wr_ent      = '{cls: req_class, svc: service_len, arr: now};
			end
			S_SCAN: begin
				ram_rd_addr = last ? pos_nx + IW'(1) : idx_q + IW'(1);
			end
			S_COMPACT: begin
				ram_rd_addr = idx_q + IW'(1);
				ram_wr_en   = 1'b1;
			end
			default: ram_rd_addr = '0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			drop_q[0]   <= '0;
			drop_q[1]   <= '0;
			drop_q[2]   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (accept && opcode == OP_INSERT && req_class != 2'd0) begin
						if (!full) begin
							count_q <= count_q + CW'(1);
						end else begin
							drop_q[dsel] <= drop_inc;
						end
					end
				end
				S_SCAN: begin
					if (last) begin
						idx_q <= pos_nx + IW'(1);
						if (pos_last) begin
							count_q <= count_q - CW'(1);
						end
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_COMPACT: begin
					idx_q <= idx_q + IW'(1);
					if (last) begin
						count_q <= count_q - CW'(1);
					end
				end
				default: idx_q <= idx_q;
			endcase
			// output register handshake
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			now_q <= now;
			if (opcode == OP_INSERT) begin
				if (req_class == 2'd0) begin
					res_status_q <= ST_DROPPED;
					res_drop_q   <= '0;
				end else if (!full) begin
					res_status_q <= ST_INSERTED;
					res_drop_q   <= drop_cur;
				end else begin
					res_status_q <= ST_DROPPED;
					res_drop_q   <= drop_inc;
				end
			end else begin
				res_status_q <= (count_q == '0) ? ST_EMPTY : ST_DEQUEUED;
				res_drop_q   <= '0;
			end
		end
		// best candidate so far in the scan
		if (state_q == S_SCAN && take) begin
			best_cls_q <= rd_ent.cls;
			best_svc_q <= rd_ent.svc;
			best_arr_q <= rd_ent.arr;
			best_pos_q <= idx_q;
		end
		// load result into the output register
		if (state_q == S_FINISH && out_free) begin
			out_status_q  <= res_status_q;
			out_class_q   <= deq_res ? best_cls_q : 2'd0;
			out_service_q <= deq_res ? best_svc_q : 3'd0;
			out_wait_q    <= deq_res ? now_q - best_arr_q : 16'd0;
			out_occ_q     <= cnt_ext[4:0];
			out_drop_q    <= res_drop_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign out_class   = out_class_q;
	assign out_service = out_service_q;
	assign wait_time   = out_wait_q;
	assign occupancy   = out_occ_q;
	assign drop_count  = out_drop_q;

	// checks
	`CPQ_ASSERT_IMPL(a_count_max, 1'b1, count_q <= CW'(DEPTH), "occupancy above depth")
	`CPQ_ASSERT_NEXT(a_busy_after_in, accept, state_q != S_IDLE, "idle after input transfer")
	`CPQ_ASSERT_IMPL(a_scan_in_range, state_q == S_SCAN || state_q == S_COMPACT,
		CW'(idx_q) < count_q, "scan index beyond occupancy")
	`CPQ_ASSERT_IMPL(a_deq_class, out_valid_q && out_status_q == ST_DEQUEUED,
		out_class_q != 2'd0, "dequeued entry without class")

endmodule

`default_nettype wire
